[sv/assert_macros.svh]
// assertion helpers shared by the checker modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define NSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// next-cycle implication, disabled while in reset
`define NSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

[sv/nsc_pkg.sv]
package nsc_pkg;

	localparam int unsigned NSC_MAX_LEN = 128;
	localparam int unsigned NSC_Q_DEPTH = 2;

	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_STAR   = 8'h2A;
	localparam logic [7:0] CHAR_CR     = 8'h0D;
	localparam logic [7:0] CHAR_LF     = 8'h0A;
	localparam logic [7:0] CHAR_G      = 8'h47;
	localparam logic [7:0] CHAR_P      = 8'h50;
	localparam logic [7:0] HEX_DIGIT_BASE = 8'h30;
	localparam logic [7:0] HEX_ALPHA_BASE = 8'h37;

	localparam int unsigned NUM_STD_IDS  = 18;
	localparam int unsigned NUM_PUBX_IDS = 5;
	localparam logic [4:0] KIND_UNKNOWN   = 5'd0;
	localparam logic [4:0] KIND_PUBX_BASE = 5'd19;

	localparam logic [23:0] STD_IDS [NUM_STD_IDS] = '{
		"DMT", "GBQ", "GBS", "GGA", "GLL", "GLQ", "GNQ", "GNS", "GPQ",
		"GRS", "GSA", "GST", "GSV", "RMC", "TXT", "VLW", "VTG", "ZDA"
	};

	localparam logic [15:0] PUBX_IDS [NUM_PUBX_IDS] = '{"41", "00", "40", "03", "04"};

	typedef enum logic [1:0] {
		ST_ACCEPT   = 2'd0,
		ST_CSUM_ERR = 2'd1,
		ST_REJECT   = 2'd2
	} status_t;

	typedef logic [6:0][7:0] hdr_t;
	typedef logic [3:0][7:0] recent_t;

	// one finished sentence, handed from the byte front end to the verdict stage
	typedef struct packed {
		logic       reject;
		logic [7:0] csum;
		logic [7:0] dig_hi;
		logic [7:0] dig_lo;
		logic [7:0] length;
		hdr_t       hdr;
	} sent_rec_t;

	typedef struct packed {
		logic full;
		logic head_valid;
	} q_stat_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] r;
		if (nib <= 4'd9) begin
			r = HEX_DIGIT_BASE + {4'd0, nib};
		end else begin
			r = HEX_ALPHA_BASE + {4'd0, nib};
		end
		return r;
	endfunction

	function automatic logic [4:0] decode_kind(input hdr_t hdr);
		logic [4:0] k;
		k = KIND_UNKNOWN;
		if (hdr[0] == CHAR_G) begin
			for (int i = NUM_STD_IDS - 1; i >= 0; i--) begin
				if ({hdr[2], hdr[3], hdr[4]} == STD_IDS[i]) begin
					k = 5'(i + 1);
				end
			end
		end else if (hdr[0] == CHAR_P) begin
			for (int i = NUM_PUBX_IDS - 1; i >= 0; i--) begin
				if ({hdr[5], hdr[6]} == PUBX_IDS[i]) begin
					k = KIND_PUBX_BASE + 5'(i);
				end
			end
		end
		return k;
	endfunction

endpackage

[sv/nsc_front.sv]
`include "assert_macros.svh"

module nsc_front import nsc_pkg::*; #(
	parameter int unsigned MAX_LEN = NSC_MAX_LEN
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      rx_valid,
	output logic      rx_stall,
	input  logic [7:0] rx_byte,
	input  q_stat_t   q_stat,
	output logic      push,
	output sent_rec_t push_rec
);

	localparam logic [7:0] MaxLen = 8'(MAX_LEN);

	logic [7:0] byte_cnt_q;
	logic [7:0] xor_q;
	recent_t    recent_q;
	hdr_t       hdr_q;
	logic       dollar_q;
	logic       overlen_q;

	logic       accept;
	logic       is_end;
	logic       short_s;
	logic [7:0] csum_full;

	assign rx_stall = q_stat.full;
	assign accept   = rx_valid && !rx_stall;
	assign is_end   = (rx_byte == CHAR_LF) && (byte_cnt_q != 8'd0) && (recent_q[3] == CHAR_CR);
	assign push     = accept && is_end;

	always_comb begin
		short_s   = byte_cnt_q < 8'd5;
		csum_full = xor_q ^ recent_q[0] ^ recent_q[1] ^ recent_q[2] ^ recent_q[3];
		push_rec.reject = !dollar_q || overlen_q || (byte_cnt_q >= MaxLen) || short_s
			|| (recent_q[0] != CHAR_STAR);
		push_rec.csum   = short_s ? 8'd0 : csum_full;
		push_rec.dig_hi = recent_q[1];
		push_rec.dig_lo = recent_q[2];
		push_rec.length = (byte_cnt_q == 8'hFF) ? 8'hFF : byte_cnt_q + 8'd1;
		push_rec.hdr    = hdr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
			xor_q      <= '0;
			recent_q   <= '0;
			hdr_q      <= '0;
			dollar_q   <= 1'b0;
			overlen_q  <= 1'b0;
		end else if (accept) begin
			recent_q <= {rx_byte, recent_q[3], recent_q[2], recent_q[1]};
			if (is_end) begin
				byte_cnt_q <= '0;
				xor_q      <= '0;
				hdr_q      <= '0;
				dollar_q   <= 1'b0;
				overlen_q  <= 1'b0;
			end else begin
				if (byte_cnt_q == 8'd0) begin
					dollar_q <= (rx_byte == CHAR_DOLLAR);
				end else begin
					xor_q <= xor_q ^ rx_byte;
				end
				for (int i = 0; i < 7; i++) begin
					if (byte_cnt_q == 8'(i + 1)) begin
						hdr_q[i] <= rx_byte;
					end
				end
				if (byte_cnt_q >= MaxLen) begin
					overlen_q <= 1'b1;
				end
				if (byte_cnt_q != 8'hFF) begin
					byte_cnt_q <= byte_cnt_q + 8'd1;
				end
			end
		end
	end

	`NSC_ASSERT_NXT(a_end_clears, clk, arst_n, push, byte_cnt_q == 8'd0 && xor_q == 8'd0)
	`NSC_ASSERT_IMP(a_idle_xor_zero, clk, arst_n, byte_cnt_q == 8'd0, xor_q == 8'd0)

endmodule

[sv/nsc_queue.sv]
`include "assert_macros.svh"

module nsc_queue import nsc_pkg::*; #(
	parameter int unsigned DEPTH = NSC_Q_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  sent_rec_t push_rec,
	input  logic      pop,
	output sent_rec_t head_rec,
	output q_stat_t   q_stat
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

	sent_rec_t       mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push;
	logic            do_pop;

	assign q_stat.full       = (cnt_q == CntW'(DEPTH));
	assign q_stat.head_valid = (cnt_q != '0);
	assign do_push  = push && !q_stat.full;
	assign do_pop   = pop && q_stat.head_valid;
	assign head_rec = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	`NSC_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CntW'(DEPTH))
	`NSC_ASSERT_NXT(a_cnt_grows, clk, arst_n, do_push && !do_pop, cnt_q == $past(cnt_q) + CntW'(1))

endmodule

[sv/nsc_back.sv]
`include "assert_macros.svh"

module nsc_back import nsc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_stat_t   q_stat,
	input  sent_rec_t head_rec,
	output logic      pop,
	output logic      res_valid,
	input  logic      res_stall,
	output logic [1:0] status,
	output logic [4:0] message_kind,
	output logic [7:0] sentence_length,
	output logic [7:0] computed_checksum
);

	logic       out_valid_q;
	status_t    status_q;
	logic [4:0] kind_q;
	logic [7:0] len_q;
	logic [7:0] csum_q;
	status_t    verdict;

	assign pop = q_stat.head_valid && (!out_valid_q || !res_stall);

	always_comb begin
		if (head_rec.reject) begin
			verdict = ST_REJECT;
		end else if ((head_rec.dig_hi != hex_char(head_rec.csum[7:4]))
			|| (head_rec.dig_lo != hex_char(head_rec.csum[3:0]))) begin
			verdict = ST_CSUM_ERR;
		end else begin
			verdict = ST_ACCEPT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= verdict;
			kind_q   <= decode_kind(head_rec.hdr);
			len_q    <= head_rec.length;
			csum_q   <= head_rec.csum;
		end
	end

	assign res_valid         = out_valid_q;
	assign status            = status_q;
	assign message_kind      = kind_q;
	assign sentence_length   = len_q;
	assign computed_checksum = csum_q;

	`NSC_ASSERT_IMP(a_status_legal, clk, arst_n, out_valid_q,
		status_q == ST_ACCEPT || status_q == ST_CSUM_ERR || status_q == ST_REJECT)

endmodule

[sv/nmea_sentence_checker_top.sv]
// res_valid: the record of the LF's sentence is queued, then registered in the verdict stage when it is popped
// throughput: one byte per cycle; the front stalls only when the sentence queue is full
// per-byte work is a counter, an xor and a four-byte shift, all registered when the byte is taken
// reset: arst_n clears counters, header and recent bytes, queue pointers and output valid
// no clearing pass: the block takes bytes from the first cycle after reset
module nmea_sentence_checker_top import nsc_pkg::*; #(
	parameter int unsigned MAX_LEN = NSC_MAX_LEN,
	parameter int unsigned Q_DEPTH = NSC_Q_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	// received byte stream
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	// one result per sentence
	output logic       res_valid,
	input  logic       res_stall,
	output logic [1:0] status,
	output logic [4:0] message_kind,
	output logic [7:0] sentence_length,
	output logic [7:0] computed_checksum
);

	// front to queue: finished sentence records
	logic      push;
	sent_rec_t push_rec;
	// queue to back: head record and fill status
	sent_rec_t head_rec;
	q_stat_t   q_stat;
	logic      pop;

	// byte front end: tracks count, xor, header and trailing bytes, spots CR LF
	nsc_front #(
		.MAX_LEN (MAX_LEN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.rx_byte  (rx_byte),
		.q_stat   (q_stat),
		.push     (push),
		.push_rec (push_rec)
	);

	// short queue so the byte side keeps going while a result is stalled
	nsc_queue #(
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head_rec (head_rec),
		.q_stat   (q_stat)
	);

	// verdict stage: hex digit compare, message kind decode, registered result
	nsc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_stat            (q_stat),
		.head_rec          (head_rec),
		.pop               (pop),
		.res_valid         (res_valid),
		.res_stall         (res_stall),
		.status            (status),
		.message_kind      (message_kind),
		.sentence_length   (sentence_length),
		.computed_checksum (computed_checksum)
	);

endmodule
